[hdl/distance_vector_table_update_defines.svh]
// Assertion macros shared by the checker of the routing table engine.
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dvt_pkg.sv]
// Types and constants of the distance-vector routing table engine.
`timescale 1ns / 1ps

package dvt_pkg;

  // Fixed field widths.
  localparam int ADDR_W      = 32;
  localparam int IFACE_W     = 2;
  localparam int ADV_COST_W  = 10;
  localparam int READ_IDX_W  = 6;
  localparam int STATUS_W    = 3;
  localparam int OUT_COST_W  = 10;
  localparam int OUT_COUNT_W = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_REG_IFACES = 4;
  // Width of the cost sum before saturation; covers any infinity up to 65535.
  localparam int CALC_W      = 17;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IF_COST_BASE  = 3'd4;

  // Request actions.
  localparam logic ACT_APPLY = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NO_LINK  = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_KEPT     = 3'd3,
    ST_INSERTED = 3'd4,
    ST_FULL     = 3'd5,
    ST_READ     = 3'd6
  } status_e;

  // Control part of the token that walks down the cell chain.
  typedef struct packed {
    logic    active;
    logic    is_read;
    logic    done;
    logic    e_valid;
    status_e status;
  } tok_ctrl_t;

  // Fixed-width data part of the token.
  typedef struct packed {
    logic [ADDR_W-1:0]     dest;
    logic [ADDR_W-1:0]     nbr;
    logic [IFACE_W-1:0]    iface;
    logic [READ_IDX_W-1:0] ridx;
    logic [ADDR_W-1:0]     e_dest;
    logic [ADDR_W-1:0]     e_hop;
    logic [IFACE_W-1:0]    e_iface;
  } tok_data_t;

endpackage

[hdl/dvt_cell.sv]
// One table slot of the routing engine: holds a route and relays the request token.
`timescale 1ns / 1ps

module dvt_cell #(
  parameter int CellIdx = 0,
  parameter int IdxW    = 6,
  parameter int CntW    = 7,
  parameter int CostW   = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CntW-1:0]     count_i,
  input  dvt_pkg::tok_ctrl_t  ctrl_i,
  input  dvt_pkg::tok_data_t  data_i,
  input  logic [CostW-1:0]    cost_i,
  input  logic [IdxW-1:0]     slot_i,
  input  logic [CostW-1:0]    e_cost_i,
  output dvt_pkg::tok_ctrl_t  ctrl_o,
  output dvt_pkg::tok_data_t  data_o,
  output logic [CostW-1:0]    cost_o,
  output logic [IdxW-1:0]     slot_o,
  output logic [CostW-1:0]    e_cost_o
);

  localparam int CmpW = (IdxW > dvt_pkg::READ_IDX_W) ? IdxW : dvt_pkg::READ_IDX_W;

  // Stored route of this slot.
  logic [dvt_pkg::ADDR_W-1:0]  dest_q;
  logic [dvt_pkg::ADDR_W-1:0]  hop_q;
  logic [dvt_pkg::IFACE_W-1:0] iface_q;
  logic [CostW-1:0]            cost_q;

  // Token stage registers.
  dvt_pkg::tok_ctrl_t ctrl_q, ctrl_d;
  dvt_pkg::tok_data_t data_q, data_d;
  logic [CostW-1:0]   cost_q2;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic [CostW-1:0]   e_cost_q, e_cost_d;

  logic occupied, at_end, pending, dest_hit, replace, read_hit;
  logic wr_dest, wr_route;

  // Slot status relative to the fill count and the request in flight.
  assign occupied = CntW'(CellIdx) < count_i;
  assign at_end   = CntW'(CellIdx) == count_i;
  assign pending  = ctrl_i.active && !ctrl_i.done;
  assign dest_hit = occupied && (dest_q == data_i.dest);
  assign replace  = (hop_q == data_i.nbr) || (cost_q > cost_i);
  assign read_hit = CmpW'(data_i.ridx) == CmpW'(CellIdx);

  assign wr_dest  = pending && !ctrl_i.is_read && at_end;
  assign wr_route = pending && !ctrl_i.is_read && ((dest_hit && replace) || at_end);

  // Resolve the request if it concerns this slot, otherwise pass it on.
  always_comb begin
    ctrl_d   = ctrl_i;
    data_d   = data_i;
    slot_d   = slot_i;
    e_cost_d = e_cost_i;
    if (pending && ctrl_i.is_read && read_hit) begin
      ctrl_d.done    = 1'b1;
      ctrl_d.status  = dvt_pkg::ST_READ;
      ctrl_d.e_valid = occupied;
      if (occupied) begin
        data_d.e_dest  = dest_q;
        data_d.e_hop   = hop_q;
        data_d.e_iface = iface_q;
        e_cost_d       = cost_q;
      end
    end else if (pending && !ctrl_i.is_read && dest_hit) begin
      ctrl_d.done    = 1'b1;
      ctrl_d.e_valid = 1'b1;
      slot_d         = IdxW'(CellIdx);
      data_d.e_dest  = dest_q;
      if (replace) begin
        ctrl_d.status  = dvt_pkg::ST_UPDATED;
        data_d.e_hop   = data_i.nbr;
        data_d.e_iface = data_i.iface;
        e_cost_d       = cost_i;
      end else begin
        ctrl_d.status  = dvt_pkg::ST_KEPT;
        data_d.e_hop   = hop_q;
        data_d.e_iface = iface_q;
        e_cost_d       = cost_q;
      end
    end else if (pending && !ctrl_i.is_read && at_end) begin
      ctrl_d.done    = 1'b1;
      ctrl_d.e_valid = 1'b1;
      ctrl_d.status  = dvt_pkg::ST_INSERTED;
      slot_d         = IdxW'(CellIdx);
      data_d.e_dest  = data_i.dest;
      data_d.e_hop   = data_i.nbr;
      data_d.e_iface = data_i.iface;
      e_cost_d       = cost_i;
    end
  end

  // Route storage.
  always_ff @(posedge clk_i) begin
    if (wr_dest) begin
      dest_q <= data_i.dest;
    end
    if (wr_route) begin
      hop_q   <= data_i.nbr;
      iface_q <= data_i.iface;
      cost_q  <= cost_i;
    end
  end

  // Token control to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  // Token payload to the next cell.
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    cost_q2  <= cost_i;
    slot_q   <= slot_d;
    e_cost_q <= e_cost_d;
  end

  assign ctrl_o   = ctrl_q;
  assign data_o   = data_q;
  assign cost_o   = cost_q2;
  assign slot_o   = slot_q;
  assign e_cost_o = e_cost_q;

endmodule

[hdl/distance_vector_table_update.sv]
// Top level of the distance-vector routing table engine.
`timescale 1ns / 1ps

// A request is taken when start_i is high and busy_o is low; one request is in
// flight at a time. Its result passes the launch register and the register of
// every table cell, and appears on the result ports for a single cycle marked by
// done_o; busy_o drops in that same cycle. The receiver cannot stall the result,
// so it must capture it then. The request token walks the chain of table cells,
// one cell per cycle, whatever the request finds. Each cell holds one route.
// The configuration port is always ready; write it only while busy_o is low.
module distance_vector_table_update #(
  parameter int TABLE_DEPTH   = 64,
  parameter int NUM_IFACES    = 4,
  parameter int INFINITE_COST = 999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Request.
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [31:0] neighbor_addr_i,
  input  logic [31:0] recv_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [9:0]  adv_cost_i,
  input  logic [5:0]  read_index_i,
  // Result.
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_dest_o,
  output logic [31:0] entry_next_hop_o,
  output logic [1:0]  entry_interface_o,
  output logic [9:0]  entry_cost_o,
  output logic [6:0]  entry_count_o
);

  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int CostW = $clog2(INFINITE_COST + 1);

  logic [dvt_pkg::ADDR_W-1:0]     own_addr_q [dvt_pkg::NUM_REG_IFACES];
  logic [dvt_pkg::ADV_COST_W-1:0] if_cost_q  [dvt_pkg::NUM_REG_IFACES];
  logic [CntW-1:0] count_q, count_d;
  logic            busy_q;
  logic            accept;

  // Front-end lookup results.
  logic                        link_hit, own_hit;
  logic [dvt_pkg::IFACE_W-1:0] iface_c;
  logic [dvt_pkg::CALC_W-1:0]  sum_c;
  logic [CostW-1:0]            new_cost_c;

  // Token chain wiring; index 0 is the launch register.
  dvt_pkg::tok_ctrl_t ctrl_w   [TABLE_DEPTH+1];
  dvt_pkg::tok_data_t data_w   [TABLE_DEPTH+1];
  logic [CostW-1:0]   cost_w   [TABLE_DEPTH+1];
  logic [IdxW-1:0]    slot_w   [TABLE_DEPTH+1];
  logic [CostW-1:0]   e_cost_w [TABLE_DEPTH+1];

  dvt_pkg::tok_ctrl_t launch_ctrl_q, launch_ctrl_d;
  dvt_pkg::tok_data_t launch_data_q, launch_data_d;
  logic [CostW-1:0]   launch_cost_q;

  dvt_pkg::tok_ctrl_t tail_ctrl;
  dvt_pkg::tok_data_t tail_data;
  dvt_pkg::status_e   final_status;

  // Result registers.
  logic        done_q;
  logic [2:0]  status_q;
  logic [5:0]  slot_q;
  logic        e_valid_q;
  logic [31:0] e_dest_q, e_hop_q;
  logic [1:0]  e_iface_q;
  logic [9:0]  e_cost_q;
  logic [6:0]  e_count_q;

  assign accept      = start_i && !busy_q;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dvt_pkg::NUM_REG_IFACES; i++) begin
        own_addr_q[i] <= '0;
        if_cost_q[i]  <= 10'd1;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i < dvt_pkg::REG_IF_COST_BASE) begin
        own_addr_q[cfg_index_i[1:0] - dvt_pkg::REG_OWN_ADDR_BASE[1:0]] <= cfg_data_i;
      end else begin
        if_cost_q[cfg_index_i[1:0]] <= cfg_data_i[dvt_pkg::ADV_COST_W-1:0];
      end
    end
  end

  // Interface lookup (lowest match wins) and own-destination check.
  always_comb begin
    link_hit = 1'b0;
    own_hit  = 1'b0;
    iface_c  = '0;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if (own_addr_q[i] == recv_addr_i) begin
        link_hit = 1'b1;
        iface_c  = 2'(i);
      end
      if (own_addr_q[i] == dest_addr_i) begin
        own_hit = 1'b1;
      end
    end
  end

  // Path cost with saturation at infinity.
  assign sum_c = dvt_pkg::CALC_W'(adv_cost_i) + dvt_pkg::CALC_W'(if_cost_q[iface_c]);
  assign new_cost_c = (sum_c >= dvt_pkg::CALC_W'(INFINITE_COST)) ?
                      CostW'(INFINITE_COST) : CostW'(sum_c);

  // Build the token for an accepted request.
  always_comb begin
    launch_ctrl_d = '0;
    launch_data_d = '0;
    if (accept) begin
      launch_ctrl_d.active  = 1'b1;
      launch_ctrl_d.is_read = (action_i == dvt_pkg::ACT_READ);
      if (action_i == dvt_pkg::ACT_APPLY && !link_hit) begin
        launch_ctrl_d.done   = 1'b1;
        launch_ctrl_d.status = dvt_pkg::ST_NO_LINK;
      end else if (action_i == dvt_pkg::ACT_APPLY && own_hit) begin
        launch_ctrl_d.done   = 1'b1;
        launch_ctrl_d.status = dvt_pkg::ST_SKIPPED;
      end
      launch_data_d.dest  = dest_addr_i;
      launch_data_d.nbr   = neighbor_addr_i;
      launch_data_d.iface = iface_c;
      launch_data_d.ridx  = read_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_ctrl_q <= '0;
    end else begin
      launch_ctrl_q <= launch_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    launch_data_q <= launch_data_d;
    launch_cost_q <= new_cost_c;
  end

  assign ctrl_w[0]   = launch_ctrl_q;
  assign data_w[0]   = launch_data_q;
  assign cost_w[0]   = launch_cost_q;
  assign slot_w[0]   = '0;
  assign e_cost_w[0] = '0;

  // Chain of table cells.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    dvt_cell #(
      .CellIdx (k),
      .IdxW    (IdxW),
      .CntW    (CntW),
      .CostW   (CostW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .count_i  (count_q),
      .ctrl_i   (ctrl_w[k]),
      .data_i   (data_w[k]),
      .cost_i   (cost_w[k]),
      .slot_i   (slot_w[k]),
      .e_cost_i (e_cost_w[k]),
      .ctrl_o   (ctrl_w[k+1]),
      .data_o   (data_w[k+1]),
      .cost_o   (cost_w[k+1]),
      .slot_o   (slot_w[k+1]),
      .e_cost_o (e_cost_w[k+1])
    );
  end

  // Close out the request leaving the chain.
  assign tail_ctrl = ctrl_w[TABLE_DEPTH];
  assign tail_data = data_w[TABLE_DEPTH];

  always_comb begin
    if (tail_ctrl.done) begin
      final_status = tail_ctrl.status;
    end else if (tail_ctrl.is_read) begin
      final_status = dvt_pkg::ST_READ;
    end else begin
      final_status = dvt_pkg::ST_FULL;
    end
  end

  assign count_d = (tail_ctrl.active && final_status == dvt_pkg::ST_INSERTED) ?
                   count_q + CntW'(1) : count_q;

  // Fill count and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= tail_ctrl.active;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail_ctrl.active) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (tail_ctrl.active) begin
      status_q  <= final_status;
      slot_q    <= tail_ctrl.is_read ? tail_data.ridx : 6'(slot_w[TABLE_DEPTH]);
      e_valid_q <= tail_ctrl.e_valid;
      e_dest_q  <= tail_data.e_dest;
      e_hop_q   <= tail_data.e_hop;
      e_iface_q <= tail_data.e_iface;
      e_cost_q  <= dvt_pkg::OUT_COST_W'(e_cost_w[TABLE_DEPTH]);
      e_count_q <= dvt_pkg::OUT_COUNT_W'(count_d);
    end
  end

  assign busy_o            = busy_q;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign slot_o            = slot_q;
  assign entry_valid_o     = e_valid_q;
  assign entry_dest_o      = e_dest_q;
  assign entry_next_hop_o  = e_hop_q;
  assign entry_interface_o = e_iface_q;
  assign entry_cost_o      = e_cost_q;
  assign entry_count_o     = e_count_q;

endmodule

[hdl/dvt_checker.sv]
// Port-level checker of the routing table engine and its bind.
`timescale 1ns / 1ps
`include "distance_vector_table_update_defines.svh"

module dvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [5:0]  slot_o,
  input logic        entry_valid_o,
  input logic [6:0]  entry_count_o
);

  logic       empty_done, ins_done;
  logic [5:0] last_slot;

  // Results that carry no table entry, and inserts with the slot they should name.
  assign empty_done = done_o && (status_o == dvt_pkg::ST_NO_LINK ||
                                 status_o == dvt_pkg::ST_SKIPPED ||
                                 status_o == dvt_pkg::ST_FULL);
  assign ins_done   = done_o && status_o == dvt_pkg::ST_INSERTED;
  assign last_slot  = entry_count_o[5:0] - 6'd1;

  // An accepted request keeps the block busy until its result.
  `DVT_ASSERT_NEXT(a_busy_after_start, start_i && !busy_o, busy_o, "busy not raised")

  // The result strobe ends the busy period.
  `DVT_ASSERT_SAME(a_done_not_busy, done_o, !busy_o, "result while still busy")

  // A request without a table entry reports slot zero and no entry.
  `DVT_ASSERT_SAME(a_no_entry, empty_done, !entry_valid_o && slot_o == 6'd0, "entry on empty result")

  // An insert lands in the last slot of the grown table.
  `DVT_ASSERT_SAME(a_insert_slot, ins_done, entry_valid_o && slot_o == last_slot, "bad insert slot")

endmodule

bind distance_vector_table_update dvt_checker u_dvt_checker (.*);
